>>> sv/wsm_pkg.sv
// Package for the wildcard string matcher: payload types, codes and constants.
package wsm_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_PLEN = 3'd0;
	localparam logic [2:0] REG_PAT0 = 3'd1;
	localparam int         CFG_IDX_W = 3;

	// Pattern byte that matches any text byte
	localparam logic [7:0] WILDCARD = 8'h5F;

	// Pattern registers hold this many bytes
	localparam int PAT_REG_BYTES = 32;

	// Match counter saturation value
	localparam logic [16:0] MATCH_CAP = 17'd65536;

	// Result kinds
	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Summary status codes
	localparam logic [2:0] ST_FOUND      = 3'd0;
	localparam logic [2:0] ST_NONE       = 3'd1;
	localparam logic [2:0] ST_EMPTY_PAT  = 3'd2;
	localparam logic [2:0] ST_EMPTY_TEXT = 3'd3;
	localparam logic [2:0] ST_TOO_LONG   = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
		logic       no_byte;
	} wsm_in_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] match_start;
		logic [16:0] match_total;
		logic [2:0]  status;
		logic        last_of_run;
	} wsm_out_t;

	// Control from the pattern block to the datapath
	typedef struct packed {
		logic       busy;
		logic [5:0] plen;
	} wsm_ctl_t;

endpackage

>>> sv/wsm_cell.sv
// One matcher cell: holds one window byte and compares its incoming byte.
module wsm_cell import wsm_pkg::*; (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] din,
	input  logic [7:0] pat,
	input  logic       care,
	output logic [7:0] dout,
	output logic       hit
);

	logic [7:0] byte_q;

	// Window byte moves one cell down on every accepted text byte that fits the text limit
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

	// Compare the byte this cell is about to hold
	assign hit = !care || (din == pat);

endmodule

>>> sv/wsm_pattern.sv
// Pattern registers and the per-cell aligned pattern they drive.
module wsm_pattern import wsm_pkg::*; #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_take,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output logic [7:0]           al_pat [MAX_PATTERN],
	output logic                 al_care [MAX_PATTERN],
	output wsm_ctl_t             ctl
);

	localparam int NPAT = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;

	logic [5:0] plen_q;
	logic [7:0] pat_q [NPAT];
	logic [5:0] eff;
	logic [7:0] al_pat_d [MAX_PATTERN];
	logic       al_care_d [MAX_PATTERN];
	logic [7:0] al_pat_q [MAX_PATTERN];
	logic       al_care_q [MAX_PATTERN];
	logic [5:0] eff_q;
	logic       busy_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			for (int b = 0; b < NPAT; b++) begin
				pat_q[b] <= '0;
			end
		end else if (cfg_take) begin
			if (cfg_index == REG_PLEN) begin
				plen_q <= cfg_data[5:0];
			end
			for (int b = 0; b < NPAT; b++) begin
				if (cfg_index == REG_PAT0 + CFG_IDX_W'(b >> 3)) begin
					pat_q[b] <= cfg_data[(b & 7) * 8 +: 8];
				end
			end
		end
	end

	// Effective length, clipped to the window depth
	always_comb begin
		if (32'(plen_q) > MAX_PATTERN) begin
			eff = 6'(MAX_PATTERN);
		end else begin
			eff = plen_q;
		end
	end

	// Cell k checks pattern byte eff-1-k; bytes past the registers read as zero
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			al_pat_d[k] = '0;
			for (int j = 0; j < NPAT; j++) begin
				if (j + k + 1 == int'(eff)) begin
					al_pat_d[k] = pat_q[j];
				end
			end
			al_care_d[k] = (k < int'(eff)) && (al_pat_d[k] != WILDCARD);
		end
	end

	// Aligned copy refreshed every cycle; busy covers the cycle after a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q  <= '0;
			busy_q <= 1'b0;
			for (int k = 0; k < MAX_PATTERN; k++) begin
				al_pat_q[k]  <= '0;
				al_care_q[k] <= 1'b0;
			end
		end else begin
			eff_q  <= eff;
			busy_q <= cfg_take;
			for (int k = 0; k < MAX_PATTERN; k++) begin
				al_pat_q[k]  <= al_pat_d[k];
				al_care_q[k] <= al_care_d[k];
			end
		end
	end

	assign al_pat   = al_pat_q;
	assign al_care  = al_care_q;
	assign ctl.busy = busy_q;
	assign ctl.plen = eff_q;

endmodule

>>> sv/wildcard_string_matcher_top.sv
// Top level of the wildcard string matcher: cell chain, counters, result buffer.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | in_valid/in_ready   | in_data  (wsm_in_t)
//  out     | output    | out_valid/out_ready | out_data (wsm_out_t)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One text byte per cycle: all cells compare in parallel and the hit AND
// plus the counter update settle in the accepting cycle.
// An item that yields a match and a summary holds the input until the
// report leaves and the summary moves up.
// After a register write the input stalls in the next cycle while the aligned
// pattern registers reload. Reset clears counters, pattern and buffer.
// Output stalls back-pressure the input whenever a result waits in the
// output register.
module wildcard_string_matcher_top import wsm_pkg::*; #(
	parameter int MAX_PATTERN = 32,
	parameter int MAX_TEXT    = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wsm_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wsm_out_t             out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int BW = $clog2(MAX_TEXT + 1);
	localparam int DW = (BW > 16) ? BW : 16;

	logic [7:0] al_pat [MAX_PATTERN];
	logic       al_care [MAX_PATTERN];
	wsm_ctl_t   ctl;
	logic [7:0] chain [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] hit;

	logic          take;
	logic          has_byte;
	logic          room;
	logic          shift;
	logic [BW-1:0] bytes_q;
	logic [BW-1:0] bytes_nx;
	logic [16:0]   matches_q;
	logic [16:0]   matches_nx;
	logic          ovf_q;
	logic          ovf_nx;
	logic          found;
	logic [DW-1:0] start;
	wsm_out_t      r_match;
	wsm_out_t      r_sum;
	wsm_out_t      out_q;
	wsm_out_t      pend_q;
	logic          ov_q;
	logic          pv_q;

	assign cfg_ready = 1'b1;

	wsm_pattern #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_pattern (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_take  (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.al_pat    (al_pat),
		.al_care   (al_care),
		.ctl       (ctl)
	);

	// Cell chain, newest byte enters cell 0
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		wsm_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.din   ((k == 0) ? in_data.text_byte : chain[(k == 0) ? 0 : k - 1]),
			.pat   (al_pat[k]),
			.care  (al_care[k]),
			.dout  (chain[k]),
			.hit   (hit[k])
		);
	end

	// Input acceptance and counters for this item
	assign in_ready = !ctl.busy && !pv_q && (!ov_q || out_ready);
	assign take     = in_valid && in_ready;
	assign has_byte = !in_data.no_byte;
	assign room     = bytes_q != BW'(MAX_TEXT);
	assign shift    = take && has_byte && room;
	assign bytes_nx = shift ? bytes_q + 1'b1 : bytes_q;
	assign ovf_nx   = ovf_q || (take && has_byte && !room);
	assign found    = shift && (ctl.plen != '0) && (32'(bytes_nx) >= 32'(ctl.plen)) && (&hit);
	assign matches_nx = (found && matches_q != MATCH_CAP) ? matches_q + 1'b1 : matches_q;
	assign start    = DW'(bytes_nx) - DW'(ctl.plen);

	// Match report
	always_comb begin
		r_match.kind        = KIND_MATCH;
		r_match.match_start = start[15:0];
		r_match.match_total = '0;
		r_match.status      = ST_FOUND;
		r_match.last_of_run = !in_data.is_last;
	end

	// Summary, status checked in priority order
	always_comb begin
		r_sum.kind        = KIND_SUMMARY;
		r_sum.match_start = '0;
		r_sum.match_total = matches_nx;
		r_sum.last_of_run = 1'b1;
		priority if (ctl.plen == '0) begin
			r_sum.status      = ST_EMPTY_PAT;
			r_sum.match_total = '0;
		end else if (bytes_nx == '0) begin
			r_sum.status      = ST_EMPTY_TEXT;
			r_sum.match_total = '0;
		end else if (ovf_nx) begin
			r_sum.status = ST_TOO_LONG;
		end else if (matches_nx != '0) begin
			r_sum.status = ST_FOUND;
		end else begin
			r_sum.status = ST_NONE;
		end
	end

	// Text counters, cleared at end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q   <= '0;
			matches_q <= '0;
			ovf_q     <= 1'b0;
		end else if (take) begin
			if (in_data.is_last) begin
				bytes_q   <= '0;
				matches_q <= '0;
				ovf_q     <= 1'b0;
			end else begin
				bytes_q   <= bytes_nx;
				matches_q <= matches_nx;
				ovf_q     <= ovf_nx;
			end
		end
	end

	// Output register plus one pending entry for the trailing summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			pv_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) begin
				ov_q <= pv_q;
				pv_q <= 1'b0;
			end
			if (take && (found || in_data.is_last)) begin
				ov_q <= 1'b1;
				pv_q <= found && in_data.is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ov_q && out_ready && pv_q) begin
			out_q <= pend_q;
		end
		if (take) begin
			if (found) begin
				out_q  <= r_match;
				pend_q <= r_sum;
			end else if (in_data.is_last) begin
				out_q <= r_sum;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

endmodule

>>> sv/wsm_checker.sv
// Port-level checks for the wildcard string matcher, bound to the top level.
module wsm_checker import wsm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input wsm_in_t              in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input wsm_out_t             out_data,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Input waits while the aligned pattern reloads
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input accepted during pattern reload");

	// End of text always yields a result next cycle
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.is_last |=> out_valid)
		else $error("no result after end of text");

	// A match report not marked final is followed by its summary
	a_sum_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.kind == KIND_MATCH && !out_data.last_of_run
		|=> out_valid && out_data.kind == KIND_SUMMARY)
		else $error("summary missing after match report");

endmodule

bind wildcard_string_matcher_top wsm_checker u_wsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

>>> dv/wildcard_string_matcher_top_test.sv
// Self-checking testbench for the wildcard string matcher: random texts, patterns and stalls.
`timescale 1ns / 100ps

module wildcard_string_matcher_top_test;
	import wsm_pkg::*;

	localparam int TEXT_LIMIT      = 65536;
	localparam int PAT_REGS        = 4;
	localparam int ITEMS_TARGET    = 1200;
	localparam int QUIET_TAIL      = 200;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT     = 3000;

	// Tracks text state and pattern registers, predicts match reports and summaries
	class text_match_board;
		bit [7:0]   window[PAT_REG_BYTES];  // entry 0 holds the newest byte
		bit [7:0]   pattern[PAT_REG_BYTES];
		bit [5:0]   plen;
		int unsigned bytes_seen;
		int unsigned matches_seen;
		bit         overflowed;
		wsm_out_t   pending[$];
		int         mismatch_count;

		function void clear_text();
			foreach (window[i]) window[i] = 8'h00;
			bytes_seen   = 0;
			matches_seen = 0;
			overflowed   = 1'b0;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] word);
			int base;
			if (idx == REG_PLEN) begin
				plen = word[5:0];
			end else if (idx >= REG_PAT0 && idx < REG_PAT0 + PAT_REGS) begin
				base = (int'(idx) - int'(REG_PAT0)) * 8;
				for (int b = 0; b < 8; b++)
					pattern[base + b] = word[8*b +: 8];
			end
			// other indexes are ignored by the block
		endfunction

		function void note_text_item(wsm_in_t item);
			int unsigned eff;
			int          i;
			int          j;
			bit          hit;
			wsm_out_t    r;
			eff = (plen > PAT_REG_BYTES) ? PAT_REG_BYTES : plen;
			if (!item.no_byte) begin
				if (bytes_seen >= TEXT_LIMIT) begin
					overflowed = 1'b1;
				end else begin
					for (i = PAT_REG_BYTES - 1; i > 0; i--)
						window[i] = window[i-1];
					window[0] = item.text_byte;
					bytes_seen++;
					if (eff != 0 && bytes_seen >= eff) begin
						hit = 1'b1;
						for (j = 0; j < eff; j++)
							if (pattern[j] != WILDCARD && pattern[j] != window[eff-1-j])
								hit = 1'b0;
						if (hit) begin
							if (matches_seen < MATCH_CAP)
								matches_seen++;
							r             = '0;
							r.kind        = KIND_MATCH;
							r.match_start = 16'(bytes_seen - eff);
							r.last_of_run = !item.is_last;
							pending.push_back(r);
						end
					end
				end
			end
			// end of text: summary, then a fresh text
			if (item.is_last) begin
				r             = '0;
				r.kind        = KIND_SUMMARY;
				r.last_of_run = 1'b1;
				if (eff == 0) begin
					r.status = ST_EMPTY_PAT;
				end else if (bytes_seen == 0) begin
					r.status = ST_EMPTY_TEXT;
				end else begin
					r.match_total = 17'(matches_seen);
					if (overflowed)
						r.status = ST_TOO_LONG;
					else if (matches_seen != 0)
						r.status = ST_FOUND;
					else
						r.status = ST_NONE;
				end
				pending.push_back(r);
				clear_text();
			end
		endfunction

		function bit field_ok(string field, logic [16:0] want, logic [16:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_report(wsm_out_t got);
			wsm_out_t want;
			bit       ok;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0h", $time, got);
				mismatch_count++;
				return;
			end
			want = pending.pop_front();
			ok = field_ok("kind", want.kind, got.kind);
			ok = field_ok("match_start", want.match_start, got.match_start) & ok;
			ok = field_ok("match_total", want.match_total, got.match_total) & ok;
			ok = field_ok("status", want.status, got.status) & ok;
			ok = field_ok("last_of_run", want.last_of_run, got.last_of_run) & ok;
			if (!ok)
				mismatch_count++;
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	wsm_in_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	wsm_out_t             out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;

	text_match_board board;
	wsm_in_t         text_items[$];
	logic [5:0]      cur_len;
	logic [7:0]      cur_pat[PAT_REG_BYTES];
	int              items_done;
	int              send_idle_pct;
	int              recv_idle_pct;
	bit              hold_off_request;
	int              stall_left;
	int              quiet_cycles;

	wildcard_string_matcher_top #(
		.MAX_PATTERN(PAT_REG_BYTES),
		.MAX_TEXT   (TEXT_LIMIT)
	) DUT (.*);

	always #2 clk = ~clk;

	// Result side: check each transfer, then choose ready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_report(out_data);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall_left = HOLD_OFF_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
				stall_left = $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return "a";
			4, 5, 6:    return "b";
			7, 8:       return WILDCARD;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int idle_share();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 10;
			default: return 35;
		endcase
	endfunction

	function automatic void push_item(logic [7:0] b, bit last, bit gap);
		text_items.push_back(wsm_in_t'({b, last, gap}));
	endfunction

	// Random pattern; long ones lean on wildcards so that they still hit
	function automatic void pick_pattern();
		case ($urandom_range(0, 19))
			0:       cur_len = 6'd0;
			1:       cur_len = 6'd32;
			2:       cur_len = 6'($urandom_range(33, 63));
			default: cur_len = 6'($urandom_range(1, 8));
		endcase
		foreach (cur_pat[i])
			cur_pat[i] = (cur_len > 8 && $urandom_range(0, 9) != 0) ? WILDCARD : pick_char();
	endfunction

	// Text of len bytes with planted pattern copies and empty items in between
	function automatic void add_random_text(int len, bit close);
		int i;
		int eff;
		i = 0;
		eff = (cur_len > PAT_REG_BYTES) ? PAT_REG_BYTES : cur_len;
		while (i < len) begin
			if ($urandom_range(0, 11) == 0)
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			if (eff > 0 && i + eff <= len && $urandom_range(0, 4) == 0) begin
				for (int j = 0; j < eff; j++)
					push_item((cur_pat[j] == WILDCARD) ? pick_char() : cur_pat[j], 1'b0, 1'b0);
				i += eff;
			end else begin
				push_item(pick_char(), 1'b0, 1'b0);
				i++;
			end
		end
		if (close) begin
			if ($urandom_range(0, 4) == 0)
				push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
			else
				push_item(pick_char(), 1'b1, 1'b0);
		end
	endfunction

	task automatic send_text_item(input wsm_in_t item);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		board.note_text_item(item);
		if (!item.no_byte || item.is_last)
			items_done++;
	endtask

	task automatic send_items();
		while (text_items.size() != 0)
			send_text_item(text_items.pop_front());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] word);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
		board.apply_reg(idx, word);
	endtask

	// Writes length and all pattern registers, optionally one unmapped index
	task automatic load_pattern(input bit stray);
		logic [63:0] word;
		word = {$urandom(), $urandom()};
		word[5:0] = cur_len;
		write_reg(REG_PLEN, word);
		for (int r = 0; r < PAT_REGS; r++) begin
			for (int b = 0; b < 8; b++)
				word[8*b +: 8] = cur_pat[8*r + b];
			write_reg(CFG_IDX_W'(int'(REG_PAT0) + r), word);
		end
		if (stray)
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_PAT0) + PAT_REGS,
				(1 << CFG_IDX_W) - 1)), {$urandom(), $urandom()});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, wait for every expected result, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_phase();
		int n;
		int len;
		pick_pattern();
		load_pattern($urandom_range(0, 3) == 0);
		n = $urandom_range(2, 6);
		for (int k = 0; k < n; k++) begin
			len = (cur_len > 8) ? $urandom_range(20, 70) : $urandom_range(0, 14);
			// the last text sometimes stays open across the next pattern load
			add_random_text(len, k < n - 1 || $urandom_range(0, 5) != 0);
		end
		send_items();
		settle();
	endtask

	initial begin
		board = new();
		board.clear_text();
		items_done       = 0;
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		hold_off_request = 1'b0;
		stall_left       = 0;
		quiet_cycles     = 0;
		foreach (cur_pat[i]) cur_pat[i] = 8'h00;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pattern after reset, with and without text
		push_item("a", 1'b0, 1'b0);
		push_item("b", 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b1);
		send_items();
		settle();

		// Short pattern with a wildcard in the middle
		cur_len    = 6'd3;
		cur_pat[0] = "a";
		cur_pat[1] = WILDCARD;
		cur_pat[2] = "c";
		load_pattern(1'b1);
		push_item(8'hFF, 1'b1, 1'b1);              // empty text
		push_item("a", 1'b0, 1'b0);                // match on the closing byte
		push_item("b", 1'b0, 1'b0);
		push_item("c", 1'b1, 1'b0);
		push_item("x", 1'b0, 1'b0);                // shorter than the pattern
		push_item("y", 1'b1, 1'b0);
		push_item("a", 1'b0, 1'b0);
		push_item(8'h55, 1'b0, 1'b1);              // empty item inside the text
		push_item(8'hFF, 1'b0, 1'b0);
		push_item("c", 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);
		push_item("a", 1'b0, 1'b0);
		push_item(WILDCARD, 1'b0, 1'b0);
		push_item("c", 1'b0, 1'b0);
		push_item(8'hAA, 1'b1, 1'b1);              // text closed by an empty item
		send_items();
		settle();

		// Long receiver hold-off while every byte yields a report
		cur_len = 6'd1;
		cur_pat[0] = WILDCARD;
		load_pattern(1'b0);
		hold_off_request = 1'b1;
		add_random_text(30, 1'b1);
		send_items();
		settle();

		// Random phases with bursty idling, then a quiet tail
		while (items_done < ITEMS_TARGET - QUIET_TAIL) begin
			send_idle_pct = idle_share();
			recv_idle_pct = idle_share();
			run_random_phase();
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (items_done < ITEMS_TARGET)
			run_random_phase();
		repeat (4 * DRAIN_CYCLES) @(posedge clk);

		if (board.mismatch_count == 0 && board.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
